// ----- hdl/rrle_pkg.sv -----
// Shared types and constants for the RGBE run-length scanline decoder.
package rrle_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] LINE_MARKER = 8'd2;
   localparam logic [7:0] RUN_BASE = 8'd128;
   localparam logic [1:0] LAST_PLANE = 2'd3;

   localparam logic [1:0] KIND_SEGMENT = 2'd0;
   localparam logic [1:0] KIND_MARKER = 2'd1;
   localparam logic [1:0] KIND_WIDTH = 2'd2;
   localparam logic [1:0] KIND_OVERRUN = 2'd3;

   localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
   localparam logic [1:0] REG_LINE_COUNT = 2'd1;

   typedef enum logic [2:0] {
      PH_MARKER = 3'd0,
      PH_SKIP = 3'd1,
      PH_WHIGH = 3'd2,
      PH_WLOW = 3'd3,
      PH_CODE = 3'd4,
      PH_RUNVAL = 3'd5,
      PH_LITERAL = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic is_zero;
      logic is_run;
      logic [7:0] count;
   } byte_info_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] channel;
      logic [15:0] line_index;
      logic [15:0] start_x;
      logic [6:0] run_length;
      logic [7:0] pixel_value;
      logic image_done;
   } result_type;

endpackage

// ----- hdl/rrle_front.sv -----
// Input queue that tags each incoming byte with its code class.
module rrle_front #(
   parameter int QUEUE_DEPTH = rrle_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [7:0] data_byte,
   output logic full,
   input  logic take,
   output logic avail,
   output rrle_pkg::byte_info_type info
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   rrle_pkg::byte_info_type mem [QUEUE_DEPTH];
   rrle_pkg::byte_info_type tag;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_take;

   assign full = (count_ff == FULL_CNT);
   assign avail = (count_ff != '0);
   assign do_push = push && !full;
   assign do_take = take && avail;
   assign info = mem[rd_ptr_ff];

   always_comb begin
      tag.data = data_byte;
      tag.is_zero = (data_byte == 8'd0);
      tag.is_run = (data_byte > rrle_pkg::RUN_BASE);
      tag.count = tag.is_run ? {1'b0, data_byte[6:0]} : data_byte;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_take) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_take) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_take) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= tag;
      end
   end

endmodule

// ----- hdl/rrle_back.sv -----
// Scanline parser that executes tagged bytes and queues the results.
module rrle_back (
   input  logic clock,
   input  logic reset,
   input  logic [15:0] line_width,
   input  logic [15:0] line_count,
   input  logic avail,
   input  rrle_pkg::byte_info_type info,
   output logic take,
   input  logic pop,
   output logic empty,
   output rrle_pkg::result_type head
);

   rrle_pkg::phase_type phase_ff, phase_in;
   logic [1:0] plane_ff, plane_in;
   logic [15:0] column_ff, column_in;
   logic [15:0] row_ff, row_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] width_high_ff, width_high_in;
   logic halted_ff, halted_in;

   rrle_pkg::result_type res;
   logic res_valid;
   logic active;
   logic code_over, width_bad, marker_bad;
   logic [7:0] seg_len, rem_dec;
   logic [16:0] seg_end;
   logic end_ge, last_row, done;

   rrle_pkg::result_type outq [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] out_cnt_ff, out_cnt_in;
   logic out_push, out_pop;

   assign take = avail && (out_cnt_ff != 2'd2);
   assign active = take && !halted_ff;

   assign marker_bad = (info.data != rrle_pkg::LINE_MARKER);
   assign width_bad = ({width_high_ff, info.data} != line_width);
   assign code_over = ({1'b0, column_ff} + {9'd0, info.count}) > {1'b0, line_width};
   assign seg_len = (phase_ff == rrle_pkg::PH_LITERAL) ? 8'd1 : remaining_ff;
   assign rem_dec = remaining_ff - 8'd1;
   assign seg_end = {1'b0, column_ff} + {9'd0, seg_len};
   assign end_ge = (seg_end >= {1'b0, line_width});
   assign last_row = ((row_ff + 16'd1) == line_count);
   assign done = end_ge && (plane_ff == rrle_pkg::LAST_PLANE) && last_row;

   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         unique case (phase_ff)
            rrle_pkg::PH_MARKER: begin
               if (!marker_bad) phase_in = rrle_pkg::PH_SKIP;
            end
            rrle_pkg::PH_SKIP: phase_in = rrle_pkg::PH_WHIGH;
            rrle_pkg::PH_WHIGH: phase_in = rrle_pkg::PH_WLOW;
            rrle_pkg::PH_WLOW: begin
               if (!width_bad) phase_in = rrle_pkg::PH_CODE;
            end
            rrle_pkg::PH_CODE: begin
               if (!info.is_zero && !code_over) begin
                  phase_in = info.is_run ? rrle_pkg::PH_RUNVAL : rrle_pkg::PH_LITERAL;
               end
            end
            rrle_pkg::PH_RUNVAL, rrle_pkg::PH_LITERAL: begin
               if (end_ge) begin
                  phase_in = (plane_ff == rrle_pkg::LAST_PLANE) ?
                             rrle_pkg::PH_MARKER : rrle_pkg::PH_CODE;
               end else if (phase_ff == rrle_pkg::PH_RUNVAL || rem_dec == 8'd0) begin
                  phase_in = rrle_pkg::PH_CODE;
               end else begin
                  phase_in = rrle_pkg::PH_LITERAL;
               end
            end
            default: phase_in = rrle_pkg::PH_MARKER;
         endcase
      end
   end

   always_comb begin
      plane_in = plane_ff;
      column_in = column_ff;
      row_in = row_ff;
      remaining_in = remaining_ff;
      width_high_in = width_high_ff;
      halted_in = halted_ff;
      res_valid = 1'b0;
      res.kind = rrle_pkg::KIND_SEGMENT;
      res.channel = plane_ff;
      res.line_index = row_ff;
      res.start_x = column_ff;
      res.run_length = 7'd0;
      res.pixel_value = info.data;
      res.image_done = 1'b0;
      if (active) begin
         unique case (phase_ff)
            rrle_pkg::PH_MARKER: begin
               if (marker_bad) begin
                  res_valid = 1'b1;
                  res.kind = rrle_pkg::KIND_MARKER;
                  halted_in = 1'b1;
               end
            end
            rrle_pkg::PH_SKIP: begin
            end
            rrle_pkg::PH_WHIGH: width_high_in = info.data;
            rrle_pkg::PH_WLOW: begin
               if (width_bad) begin
                  res_valid = 1'b1;
                  res.kind = rrle_pkg::KIND_WIDTH;
                  halted_in = 1'b1;
               end else begin
                  plane_in = 2'd0;
                  column_in = 16'd0;
               end
            end
            rrle_pkg::PH_CODE: begin
               if (!info.is_zero) begin
                  if (code_over) begin
                     res_valid = 1'b1;
                     res.kind = rrle_pkg::KIND_OVERRUN;
                     halted_in = 1'b1;
                  end else begin
                     remaining_in = info.count;
                  end
               end
            end
            rrle_pkg::PH_RUNVAL, rrle_pkg::PH_LITERAL: begin
               res_valid = 1'b1;
               res.run_length = seg_len[6:0];
               res.image_done = done;
               halted_in = done;
               remaining_in = (phase_ff == rrle_pkg::PH_RUNVAL) ? 8'd0 : rem_dec;
               column_in = seg_end[15:0];
               if (end_ge) begin
                  column_in = 16'd0;
                  remaining_in = 8'd0;
                  if (plane_ff == rrle_pkg::LAST_PLANE) begin
                     plane_in = 2'd0;
                     row_in = row_ff + 16'd1;
                  end else begin
                     plane_in = plane_ff + 2'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rrle_pkg::PH_MARKER;
         plane_ff <= 2'd0;
         column_ff <= 16'd0;
         row_ff <= 16'd0;
         remaining_ff <= 8'd0;
         width_high_ff <= 8'd0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         plane_ff <= plane_in;
         column_ff <= column_in;
         row_ff <= row_in;
         remaining_ff <= remaining_in;
         width_high_ff <= width_high_in;
         halted_ff <= halted_in;
      end
   end

   assign out_push = take && res_valid;
   assign out_pop = pop && !empty;
   assign empty = (out_cnt_ff == 2'd0);
   assign head = outq[rd_ptr_ff];

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (!out_push && out_pop) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         if (out_push) wr_ptr_ff <= !wr_ptr_ff;
         if (out_pop) rd_ptr_ff <= !rd_ptr_ff;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         outq[wr_ptr_ff] <= res;
      end
   end

endmodule

// ----- hdl/rgbe_rle_scanline_decoder.sv -----
// Top level of the RGBE run-length scanline decoder with its control registers.
//
//   Channel   Ports                               Handshake
//   request   req_data_byte                       req_push / req_full
//   result    rsp_kind .. rsp_image_done          rsp_empty / rsp_pop
//   control   csr_index, csr_data                 csr_valid / csr_ready
//
// One byte is accepted every cycle while req_full is low; the parser retires
// one byte per cycle while the result queue has room. A byte is registered in the
// input queue before the parser, and its result in the result queue before a pop.
// A synchronous reset empties both queues and returns the parser to the line marker.
// The input queue holds QUEUE_DEPTH bytes and the result queue two entries, so
// a stalled result side fills them before req_full rises.
module rgbe_rle_scanline_decoder #(
   parameter int QUEUE_DEPTH = rrle_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [7:0] req_data_byte,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [1:0] rsp_channel,
   output logic [15:0] rsp_line_index,
   output logic [15:0] rsp_start_x,
   output logic [6:0] rsp_run_length,
   output logic [7:0] rsp_pixel_value,
   output logic rsp_image_done,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] line_width_ff, line_count_ff;
   logic avail, take;
   rrle_pkg::byte_info_type info;
   rrle_pkg::result_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= 16'd1;
         line_count_ff <= 16'd1;
      end else if (csr_valid) begin
         case (csr_index)
            rrle_pkg::REG_LINE_WIDTH: line_width_ff <= csr_data;
            rrle_pkg::REG_LINE_COUNT: line_count_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   rrle_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .data_byte(req_data_byte),
      .full(req_full),
      .take(take),
      .avail(avail),
      .info(info)
   );

   rrle_back u_back (
      .clock(clock),
      .reset(reset),
      .line_width(line_width_ff),
      .line_count(line_count_ff),
      .avail(avail),
      .info(info),
      .take(take),
      .pop(rsp_pop),
      .empty(rsp_empty),
      .head(head)
   );

   assign rsp_kind = head.kind;
   assign rsp_channel = head.channel;
   assign rsp_line_index = head.line_index;
   assign rsp_start_x = head.start_x;
   assign rsp_run_length = head.run_length;
   assign rsp_pixel_value = head.pixel_value;
   assign rsp_image_done = head.image_done;

endmodule

// ----- dv/rgbe_rle_scanline_decoder_tb.sv -----
// Self-checking testbench for the RGBE run-length scanline decoder.
`timescale 1ns / 100ps

module rgbe_rle_scanline_decoder_tb;

   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_BYTES = 32;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic clock;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [7:0] req_data_byte = 8'd0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [1:0] rsp_kind;
   logic [1:0] rsp_channel;
   logic [15:0] rsp_line_index;
   logic [15:0] rsp_start_x;
   logic [6:0] rsp_run_length;
   logic [7:0] rsp_pixel_value;
   logic rsp_image_done;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = rrle_pkg::REG_LINE_WIDTH;
   logic [15:0] csr_data = 16'd0;

   logic [7:0] encoded_stream[$];
   rrle_pkg::result_type decoded_records[$];
   int queued_bytes = 0;
   int accepted_bytes = 0;
   int lines_sent = 0;
   int error_count = 0;
   int stuck_cycles = 0;
   idle_mode_type idle_mode = IDLE_NONE;

   logic [15:0] width_cfg = 16'd1;
   logic [15:0] count_cfg = 16'd1;
   rrle_pkg::phase_type phase_q = rrle_pkg::PH_MARKER;
   logic [1:0] plane_q = 2'd0;
   logic [15:0] column_q = 16'd0;
   logic [15:0] row_q = 16'd0;
   logic [7:0] remaining_q = 8'd0;
   logic [7:0] width_high_q = 8'd0;
   logic halted_q = 1'b0;

   rgbe_rle_scanline_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data_byte(req_data_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_kind(rsp_kind),
      .rsp_channel(rsp_channel),
      .rsp_line_index(rsp_line_index),
      .rsp_start_x(rsp_start_x),
      .rsp_run_length(rsp_run_length),
      .rsp_pixel_value(rsp_pixel_value),
      .rsp_image_done(rsp_image_done),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit flag_error(input logic [1:0] kind, input logic [7:0] b,
                                     output rrle_pkg::result_type res);
      res = {kind, plane_q, row_q, column_q, 7'd0, b, 1'b0};
      halted_q = 1'b1;
      return 1'b1;
   endfunction

   function automatic bit emit_segment(input int len, input logic [7:0] val,
                                       input rrle_pkg::phase_type next_phase,
                                       output rrle_pkg::result_type res);
      int seg_end;
      logic done;
      seg_end = int'(column_q) + len;
      done = seg_end >= int'(width_cfg) && plane_q == rrle_pkg::LAST_PLANE
             && (row_q + 16'd1) == count_cfg;
      res = {rrle_pkg::KIND_SEGMENT, plane_q, row_q, column_q, 7'(len), val, done};
      column_q = 16'(seg_end);
      phase_q = next_phase;
      if (seg_end >= int'(width_cfg)) begin
         column_q = 16'd0;
         remaining_q = 8'd0;
         if (plane_q == rrle_pkg::LAST_PLANE) begin
            plane_q = 2'd0;
            row_q = row_q + 16'd1;
            phase_q = rrle_pkg::PH_MARKER;
         end else begin
            plane_q = plane_q + 2'd1;
            phase_q = rrle_pkg::PH_CODE;
         end
      end
      if (done) halted_q = 1'b1;
      return 1'b1;
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, output rrle_pkg::result_type res);
      int n;
      res = '0;
      if (halted_q) return 1'b0;
      case (phase_q)
         rrle_pkg::PH_MARKER: begin
            if (b != rrle_pkg::LINE_MARKER)
               return flag_error(rrle_pkg::KIND_MARKER, b, res);
            phase_q = rrle_pkg::PH_SKIP;
         end
         rrle_pkg::PH_SKIP: phase_q = rrle_pkg::PH_WHIGH;
         rrle_pkg::PH_WHIGH: begin
            width_high_q = b;
            phase_q = rrle_pkg::PH_WLOW;
         end
         rrle_pkg::PH_WLOW: begin
            if ({width_high_q, b} != width_cfg)
               return flag_error(rrle_pkg::KIND_WIDTH, b, res);
            plane_q = 2'd0;
            column_q = 16'd0;
            phase_q = rrle_pkg::PH_CODE;
         end
         rrle_pkg::PH_CODE: begin
            if (b == 8'd0) return 1'b0;
            n = (b > rrle_pkg::RUN_BASE) ? int'(b[6:0]) : int'(b);
            if (int'(column_q) + n > int'(width_cfg))
               return flag_error(rrle_pkg::KIND_OVERRUN, b, res);
            remaining_q = 8'(n);
            phase_q = (b > rrle_pkg::RUN_BASE) ? rrle_pkg::PH_RUNVAL : rrle_pkg::PH_LITERAL;
         end
         rrle_pkg::PH_RUNVAL: begin
            n = int'(remaining_q);
            remaining_q = 8'd0;
            return emit_segment(n, b, rrle_pkg::PH_CODE, res);
         end
         rrle_pkg::PH_LITERAL: begin
            remaining_q = remaining_q - 8'd1;
            return emit_segment(1, b, remaining_q == 8'd0 ?
                                rrle_pkg::PH_CODE : rrle_pkg::PH_LITERAL, res);
         end
         default: phase_q = rrle_pkg::PH_MARKER;
      endcase
      return 1'b0;
   endfunction

   function automatic bit takes_break(input idle_mode_type solo);
      if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 19;
      return idle_mode == solo && $urandom_range(99) < 75;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) $display("ERROR at %0t: %s", $time, what);
   endtask

   task automatic add_byte(input logic [7:0] b);
      encoded_stream.push_back(b);
      queued_bytes++;
   endtask

   task automatic add_header(input logic [15:0] w);
      add_byte(rrle_pkg::LINE_MARKER);
      add_byte(8'($urandom_range(255)));
      add_byte(w[15:8]);
      add_byte(w[7:0]);
   endtask

   task automatic add_plane(input int w);
      int col, n, left, k;
      col = 0;
      while (col < w) begin
         left = w - col;
         if ($urandom_range(15) == 0) add_byte(8'd0);
         if (left >= 128 && $urandom_range(2) == 0) n = 128;
         else n = $urandom_range(left < 127 ? left : 127, 1);
         if (n < 128 && $urandom_range(1) == 1) begin
            add_byte(8'(128 + n));
            add_byte(8'($urandom_range(255)));
         end else begin
            add_byte(8'(n));
            for (k = 0; k < n; k++) add_byte(8'($urandom_range(255)));
         end
         col += n;
      end
   endtask

   task automatic add_line(input int w);
      int p;
      add_header(16'(w));
      for (p = 0; p < 4; p++) add_plane(w);
      lines_sent++;
   endtask

   task automatic wait_idle();
      while (accepted_bytes != queued_bytes || decoded_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == rrle_pkg::REG_LINE_WIDTH) width_cfg = value;
      else count_cfg = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : byte_driver
      rrle_pkg::result_type outcome;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            accepted_bytes++;
            if (decode_byte(req_data_byte, outcome)) decoded_records.push_back(outcome);
         end
         if (!req_push || !req_full) begin
            if (encoded_stream.size() != 0 && !takes_break(IDLE_SENDER)) begin
               req_push <= 1'b1;
               req_data_byte <= encoded_stream.pop_front();
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : record_monitor
      rrle_pkg::result_type got, want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_kind, rsp_channel, rsp_line_index, rsp_start_x, rsp_run_length,
                   rsp_pixel_value, rsp_image_done};
            if (decoded_records.size() == 0) begin
               report_mismatch($sformatf("record kind %0d line %0d with none expected",
                                         got.kind, got.line_index));
            end else begin
               want = decoded_records.pop_front();
               if (got !== want)
                  report_mismatch($sformatf("record %h, expected %h", got, want));
            end
         end
         rsp_pop <= !takes_break(IDLE_RECEIVER);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int width, ph, start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_register(rrle_pkg::REG_LINE_COUNT, 16'd0);
      write_register(rrle_pkg::REG_LINE_WIDTH, 16'd1);
      add_header(16'd1);
      add_byte(8'h81);
      add_byte(8'h00);
      add_byte(8'h00);
      add_byte(8'h01);
      add_byte(8'hFF);
      add_byte(8'h81);
      add_byte(8'hA5);
      add_byte(8'h01);
      add_byte(8'h5A);
      lines_sent++;
      wait_idle();

      write_register(rrle_pkg::REG_LINE_WIDTH, 16'hFFFF);
      add_header(16'hFFFF);
      add_byte(8'hFF);
      add_byte(8'h3C);
      add_byte(8'h00);
      add_byte(8'hC8);
      wait_idle();
      // The width shrinks under a pending run, so that run ends past the line end.
      write_register(rrle_pkg::REG_LINE_WIDTH, 16'd24);
      add_byte(8'hC3);
      add_plane(24);
      add_plane(24);
      add_plane(24);
      lines_sent++;

      for (ph = 0; ph < 4; ph++) begin
         wait_idle();
         width = (ph == 2) ? $urandom_range(140, 128) : $urandom_range(24, 1);
         write_register(rrle_pkg::REG_LINE_WIDTH, 16'(width));
         case (ph)
            0: write_register(rrle_pkg::REG_LINE_COUNT, 16'hFFFF);
            1: write_register(rrle_pkg::REG_LINE_COUNT, 16'd1);
            default: write_register(rrle_pkg::REG_LINE_COUNT,
                        $urandom_range(1) ? 16'd0 : 16'($urandom_range(65534, 1000)));
         endcase
         idle_mode = idle_mode_type'(ph);
         start = queued_bytes;
         while (queued_bytes - start < PHASE_BYTES) add_line(width);
      end

      wait_idle();
      idle_mode = idle_mode_type'($urandom_range(3));
      width = $urandom_range(24, 1);
      write_register(rrle_pkg::REG_LINE_WIDTH, 16'(width));
      case ($urandom_range(4))
         0: add_byte($urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 3)));
         1: add_header(16'(width ^ (1 << $urandom_range(15))));
         2: begin
            add_header(16'(width));
            if ($urandom_range(1)) add_byte(8'(128 + $urandom_range(127, width + 1)));
            else add_byte(8'($urandom_range(128, width + 1)));
         end
         3: begin
            write_register(rrle_pkg::REG_LINE_COUNT, 16'(lines_sent + 1));
            add_line(width);
         end
         default: begin
            write_register(rrle_pkg::REG_LINE_WIDTH, 16'd0);
            add_header(16'd0);
            add_byte(8'd0);
            add_byte(8'($urandom_range(255, 1)));
         end
      endcase
      repeat (20) add_byte(8'($urandom_range(255)));

      while (accepted_bytes != queued_bytes || decoded_records.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/rrle_pkg.sv
hdl/rrle_front.sv
hdl/rrle_back.sv
hdl/rgbe_rle_scanline_decoder.sv
dv/rgbe_rle_scanline_decoder_tb.sv
